### hdl/tssm_pkg.sv
// ----------------------------------------------------------------------------
// Triple stack package
// Shared types and constants for the three-stack shared memory core.
// ----------------------------------------------------------------------------
package tssm_pkg;

  localparam int NUM_STACKS = 3;
  localparam int DATA_W     = 32;
  localparam int SIZE_W     = 9;
  localparam int SEL_W      = 2;

  localparam logic [DATA_W-1:0] EMPTY_WORD = '1;  // -1

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_TEST = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

### hdl/tssm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, write enable, registered read data.
// ----------------------------------------------------------------------------
module tssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hdl/triple_stack_shared_memory_core.sv
// ----------------------------------------------------------------------------
// Triple stack shared memory core
// Result: the result strobe (done) comes in the cycle after a request is taken.
// Throughput: one request per cycle unless busy; each request makes one access to the
//   entry RAM and updates one fill counter, both committed at acceptance.
// Reset: fill counters cleared (all stacks empty), capacity set to
//   STACK_DEPTH; the entry RAM is not cleared. done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module triple_stack_shared_memory_core #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  tssm_pkg::action_t             action,
  input  logic [tssm_pkg::SEL_W-1:0]    stack_select,
  input  logic signed [tssm_pkg::DATA_W-1:0] push_value,
  // result strobe
  output logic                          done,
  output logic signed [tssm_pkg::DATA_W-1:0] read_data,
  output tssm_pkg::status_t             status,
  output logic                          now_empty,
  // stack_size register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tssm_pkg::SIZE_W-1:0]   stack_size
);

  import tssm_pkg::*;

  // Fill counters hold 0..STACK_DEPTH.
  localparam int CW    = $clog2(STACK_DEPTH + 1);
  // Common width for clamping the 9-bit size against STACK_DEPTH.
  localparam int XW    = (CW > SIZE_W) ? CW : SIZE_W;
  localparam int WORDS = NUM_STACKS * STACK_DEPTH;
  localparam int AW    = $clog2(WORDS);

  // --------------------------------------------------------------------------
  // Handshakes. A register write wins over a request in the same cycle;
  // busy only holds off a request while a write is offered.
  // --------------------------------------------------------------------------
  logic cfg_take;
  logic req_take;

  assign cfg_ready = 1'b1;
  assign busy      = cfg_valid;
  assign cfg_take  = cfg_valid & cfg_ready;
  assign req_take  = start & ~busy;

  // --------------------------------------------------------------------------
  // Segment capacity: the size register is clamped to 1..STACK_DEPTH when
  // written, so only the clamped value is kept.
  // --------------------------------------------------------------------------
  logic [CW-1:0] cap;
  logic [CW-1:0] cap_next;
  logic [XW-1:0] size_ext;

  assign size_ext = XW'(stack_size);

  always_comb begin
    if (size_ext == '0) begin
      cap_next = CW'(1);
    end else if (size_ext > XW'(STACK_DEPTH)) begin
      cap_next = CW'(STACK_DEPTH);
    end else begin
      cap_next = CW'(size_ext);
    end
  end

  // --------------------------------------------------------------------------
  // Fill counters, one register per stack.
  // --------------------------------------------------------------------------
  logic [CW-1:0] fill [NUM_STACKS];
  logic [CW-1:0] fill_sel;
  logic [CW-1:0] fill_sel_next;
  logic          sel_ok;
  logic [AW-1:0] base;

  assign sel_ok = (stack_select < SEL_W'(NUM_STACKS));

  // Selected counter and segment base (stack * cap, with no multiplier).
  always_comb begin
    case (stack_select)
      2'd0: begin
        fill_sel = fill[0];
        base     = '0;
      end
      2'd1: begin
        fill_sel = fill[1];
        base     = AW'(cap);
      end
      2'd2: begin
        fill_sel = fill[2];
        base     = AW'(cap) << 1;
      end
      default: begin
        fill_sel = '0;
        base     = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Request decode: next fill, RAM access and result fields.
  // --------------------------------------------------------------------------
  logic          is_full;
  logic          is_empty;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [DATA_W-1:0] ram_rdata;
  status_t       status_next;
  logic          from_ram_next;   // result data comes from the RAM read
  logic          neg_one_next;    // result data is -1 (empty stack)

  assign is_full  = (fill_sel >= cap);
  assign is_empty = (fill_sel == '0);

  always_comb begin
    fill_sel_next = fill_sel;
    ram_we        = 1'b0;
    ram_addr      = base + AW'(fill_sel);
    status_next   = ST_DONE;
    from_ram_next = 1'b0;
    neg_one_next  = 1'b0;
    if (sel_ok) begin
      case (action)
        ACT_PUSH: begin
          if (is_full) begin
            status_next = ST_FULL;
          end else begin
            ram_we        = req_take;
            fill_sel_next = fill_sel + CW'(1);
          end
        end
        ACT_POP, ACT_PEEK: begin
          ram_addr = base + AW'(fill_sel) - AW'(1);
          if (is_empty) begin
            status_next  = ST_EMPTY;
            neg_one_next = 1'b1;
          end else begin
            from_ram_next = 1'b1;
            if (action == ACT_POP) begin
              fill_sel_next = fill_sel - CW'(1);
            end
          end
        end
        default: begin
          // test: state unchanged
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CW'(STACK_DEPTH);
      for (int i = 0; i < NUM_STACKS; i++) begin
        fill[i] <= '0;
      end
    end else if (cfg_take) begin
      // New size empties every stack.
      cap <= cap_next;
      for (int i = 0; i < NUM_STACKS; i++) begin
        fill[i] <= '0;
      end
    end else if (req_take && sel_ok) begin
      fill[stack_select[1:0]] <= fill_sel_next;
    end
  end

  // --------------------------------------------------------------------------
  // Entry RAM. Writes and counter updates commit at acceptance, so the next
  // request already sees them; no forwarding path is needed.
  // --------------------------------------------------------------------------
  tssm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (push_value),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Result stage: one-cycle strobe, data muxed from the RAM output.
  // --------------------------------------------------------------------------
  logic from_ram;
  logic neg_one;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_take;
    end
    if (req_take) begin
      status    <= status_next;
      from_ram  <= from_ram_next;
      neg_one   <= neg_one_next;
      now_empty <= ~sel_ok | (fill_sel_next == '0);
    end
  end

  always_comb begin
    if (from_ram) begin
      read_data = ram_rdata;
    end else if (neg_one) begin
      read_data = EMPTY_WORD;
    end else begin
      read_data = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_done_follows_req: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy && !rst))
    else $error("done strobe does not match taken request");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    (fill[0] <= cap) && (fill[1] <= cap) && (fill[2] <= cap))
    else $error("fill counter above capacity");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (now_empty && read_data == EMPTY_WORD))
    else $error("empty status without empty stack and -1 data");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> !now_empty)
    else $error("full status on an empty stack");

endmodule
